FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/core/tspwm_pkg.sv
// ----------------------------------------------------------------------------
// tspwm_pkg
// Widths, register codes and sine constants for the SPWM duty generator.
// ----------------------------------------------------------------------------
package tspwm_pkg;

   localparam int RAW_W      = 14;
   localparam int DUTY_IN_W  = 12;
   localparam int DUTY_OUT_W = 11;
   localparam int RED_W      = 12;
   localparam int ANGLE_W    = 16;
   localparam int OFFSET_W   = 16;
   localparam int PP_W       = 6;
   localparam int SINE_F     = 15;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int REG_IDX_W  = 3;

   localparam int COMP_SHIFT = 2;
   localparam int POS_SHIFT  = ANGLE_W - RED_W;

   localparam int NUM_STAGES = 7;
   localparam int STAGE_LAST = NUM_STAGES - 1;
   localparam int NUM_PHASES = 3;

   localparam int R_W   = ANGLE_W - 1;
   localparam int R2_W  = 2 * (ANGLE_W - 2) + 1;
   localparam int C_W   = 27;
   localparam int T_W   = 30;
   localparam int W_W   = 31;
   localparam int POLY_SHIFT = 60 - 2 * (32 - ANGLE_W);
   localparam int Y_SHIFT    = 30 - (32 - ANGLE_W);
   localparam int Y_W        = R_W + W_W - Y_SHIFT;
   localparam int S_FULL_W   = Y_W + 1 - (30 - SINE_F);
   localparam int BIAS_W     = SINE_F + 1;
   localparam int PROD_W     = DUTY_IN_W + BIAS_W;
   localparam int D_FULL_W   = PROD_W + 1 - BIAS_W;

   localparam logic [RAW_W:0]   ROUND_BIAS   = (RAW_W + 1)'(1 << (COMP_SHIFT - 1));
   localparam logic [R_W-1:0]   QUARTER_TURN = R_W'(1 << (ANGLE_W - 2));
   localparam logic [C_W-1:0]   SIN_C        = 27'd76016977;
   localparam logic [T_W-1:0]   SIN_B        = 30'd688904866;
   localparam logic [W_W-1:0]   SIN_A        = 31'd1686629713;
   localparam logic [Y_W:0]     Y_ROUND      = (Y_W + 1)'(1 << (29 - SINE_F));
   localparam logic [SINE_F-1:0] SINE_MAX    = {SINE_F{1'b1}};
   localparam logic [BIAS_W-1:0] SINE_ONE    = BIAS_W'(1 << SINE_F);
   localparam logic [PROD_W:0]   DUTY_ROUND  = (PROD_W + 1)'(1 << SINE_F);
   localparam logic [DUTY_OUT_W-1:0] DUTY_LIMIT = 11'd2047;

   localparam logic [REG_IDX_W-1:0] REG_CW_ZERO   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CW_PHASE  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CCW_ZERO  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CCW_PHASE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_POLE_PAIRS = 3'd4;

   localparam logic [OFFSET_W-1:0] RST_ZERO_OFFSET  = 16'd0;
   localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET = 16'd21845;
   localparam logic [PP_W-1:0]     RST_POLE_PAIRS   = 6'd1;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

endpackage

FILE: rtl/core/tspwm_if.sv
// ----------------------------------------------------------------------------
// tspwm request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface tspwm_req_if import tspwm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RAW_W-1:0]     raw_position;
   logic [DUTY_IN_W-1:0] duty;
   logic                 direction;

   modport source (output valid, output raw_position, output duty, output direction,
                   input ready);
   modport sink   (input valid, input raw_position, input duty, input direction,
                   output ready);
endinterface

interface tspwm_rsp_if import tspwm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DUTY_OUT_W-1:0] duty_a;
   logic [DUTY_OUT_W-1:0] duty_b;
   logic [DUTY_OUT_W-1:0] duty_c;
   logic [RED_W-1:0]      reduced_position;

   modport source (output valid, output duty_a, output duty_b, output duty_c,
                   output reduced_position, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                   input reduced_position, output ready);
endinterface

FILE: rtl/core/tspwm_lane.sv
// ----------------------------------------------------------------------------
// tspwm_lane
// One phase: electrical angle, polynomial sine and duty shaping, six stages.
// ----------------------------------------------------------------------------
module tspwm_lane import tspwm_pkg::*; (
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  logic [PP_W-1:0]       pole_pairs,
   input  logic [ANGLE_W-1:0]    mech_angle,
   input  logic [DUTY_IN_W-1:0]  duty,
   output logic [DUTY_OUT_W-1:0] duty_out
);

   logic [PP_W+ANGLE_W-1:0] elec_full;
   logic [ANGLE_W-1:0]      elec_ff;

   logic [1:0]              quad_in;
   logic [R_W-1:0]          r_in;
   logic [2*R_W-1:0]        r_sq;
   logic [1:0]              quad2_ff, quad3_ff, quad4_ff;
   logic [R_W-1:0]          r2s_ff, r3s_ff, r4s_ff;
   logic [R2_W-1:0]         sq2_ff, sq3_ff;

   logic [C_W+R2_W-1:0]     c_sq;
   logic [T_W-1:0]          t_in, t_ff;

   logic [R2_W+T_W-1:0]     sq_t;
   logic [W_W-1:0]          w_in, w_ff;

   logic [R_W+W_W-1:0]      r_w;
   logic [Y_W:0]            y_rnd;
   logic [S_FULL_W-1:0]     s_full;
   logic [SINE_F-1:0]       s_in, s_ff;
   logic                    neg_ff;

   logic [BIAS_W-1:0]       biased;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W:0]         prod_rnd;
   logic [D_FULL_W-1:0]     d_full;
   logic [DUTY_OUT_W-1:0]   d_in, d_ff;

   assign elec_full = pole_pairs * mech_angle;

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         elec_ff <= elec_full[ANGLE_W-1:0];
      end
   end

   assign quad_in = elec_ff[ANGLE_W-1:ANGLE_W-2];
   always_comb begin
      if (quad_in[0]) begin
         r_in = QUARTER_TURN - {1'b0, elec_ff[ANGLE_W-3:0]};
      end else begin
         r_in = {1'b0, elec_ff[ANGLE_W-3:0]};
      end
   end
   assign r_sq = r_in * r_in;

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         quad2_ff <= quad_in;
         r2s_ff   <= r_in;
         sq2_ff   <= r_sq[R2_W-1:0];
      end
   end

   assign c_sq = SIN_C * sq2_ff;
   assign t_in = SIN_B - T_W'(c_sq[C_W+R2_W-1:POLY_SHIFT]);

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         quad3_ff <= quad2_ff;
         r3s_ff   <= r2s_ff;
         sq3_ff   <= sq2_ff;
         t_ff     <= t_in;
      end
   end

   assign sq_t = sq3_ff * t_ff;
   assign w_in = SIN_A - W_W'(sq_t[R2_W+T_W-1:POLY_SHIFT]);

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         quad4_ff <= quad3_ff;
         r4s_ff   <= r3s_ff;
         w_ff     <= w_in;
      end
   end

   assign r_w    = r4s_ff * w_ff;
   assign y_rnd  = {1'b0, r_w[R_W+W_W-1:Y_SHIFT]} + Y_ROUND;
   assign s_full = y_rnd[Y_W:30-SINE_F];
   assign s_in   = (s_full > S_FULL_W'(SINE_MAX)) ? SINE_MAX : s_full[SINE_F-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         s_ff   <= s_in;
         neg_ff <= quad4_ff[1];
      end
   end

   always_comb begin
      if (neg_ff) begin
         biased = SINE_ONE - {1'b0, s_ff};
      end else begin
         biased = SINE_ONE + {1'b0, s_ff};
      end
   end
   assign prod     = duty * biased;
   assign prod_rnd = {1'b0, prod} + DUTY_ROUND;
   assign d_full   = prod_rnd[PROD_W:BIAS_W];
   assign d_in     = (d_full > D_FULL_W'(DUTY_LIMIT)) ? DUTY_LIMIT : d_full[DUTY_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         d_ff <= d_in;
      end
   end

   assign duty_out = d_ff;

endmodule

FILE: rtl/core/three_phase_spwm_duty_generator_top.sv
// ----------------------------------------------------------------------------
// three_phase_spwm_duty_generator_top
// Path: an accepted request enters stage 0 and is answered from stage 6.
// Throughput: one request per cycle when not stalled; seven register stages, a
// multiply in each after the first. Backpressure holds full stages in place
// back to the nearest empty stage, so bubbles are squeezed out.
// Reset: synchronous, clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_phase_spwm_duty_generator_top import tspwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tspwm_req_if.sink         req_if,
   tspwm_rsp_if.source       rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [OFFSET_W-1:0] cw_zero_ff, cw_phase_ff, ccw_zero_ff, ccw_phase_ff;
   logic [PP_W-1:0]     pole_pairs_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                csr_wr;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] en;
   pipe_ctl_type          ctl;

   logic [RED_W-1:0]      red_ff  [NUM_STAGES];
   logic [DUTY_IN_W-1:0]  duty_ff [NUM_STAGES-1];
   logic [ANGLE_W-1:0]    mech_ff [NUM_PHASES];
   logic [DUTY_OUT_W-1:0] lane_duty [NUM_PHASES];

   logic [RAW_W:0]        raw_sum;
   logic [RED_W-1:0]      red_in;
   logic [ANGLE_W-1:0]    pos, zero_sel, step_sel;
   logic [ANGLE_W-1:0]    mech_in [NUM_PHASES];

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_zero_ff    <= RST_ZERO_OFFSET;
         cw_phase_ff   <= RST_PHASE_OFFSET;
         ccw_zero_ff   <= RST_ZERO_OFFSET;
         ccw_phase_ff  <= RST_PHASE_OFFSET;
         pole_pairs_ff <= RST_POLE_PAIRS;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_CW_ZERO:    cw_zero_ff    <= pwdata[OFFSET_W-1:0];
            REG_CW_PHASE:   cw_phase_ff   <= pwdata[OFFSET_W-1:0];
            REG_CCW_ZERO:   ccw_zero_ff   <= pwdata[OFFSET_W-1:0];
            REG_CCW_PHASE:  ccw_phase_ff  <= pwdata[OFFSET_W-1:0];
            REG_POLE_PAIRS: pole_pairs_ff <= pwdata[PP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CW_ZERO:    prdata = DATA_W'(cw_zero_ff);
         REG_CW_PHASE:   prdata = DATA_W'(cw_phase_ff);
         REG_CCW_ZERO:   prdata = DATA_W'(ccw_zero_ff);
         REG_CCW_PHASE:  prdata = DATA_W'(ccw_phase_ff);
         REG_POLE_PAIRS: prdata = DATA_W'(pole_pairs_ff);
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      en[STAGE_LAST] = !valid_ff[STAGE_LAST] || rsp_if.ready;
      for (int i = STAGE_LAST - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end
   assign ctl.en       = en;
   assign req_if.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_if.valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign raw_sum  = {1'b0, req_if.raw_position} + ROUND_BIAS;
   assign red_in   = raw_sum[COMP_SHIFT+RED_W-1:COMP_SHIFT];
   assign pos      = {red_in, {POS_SHIFT{1'b0}}};
   assign zero_sel = req_if.direction ? ccw_zero_ff : cw_zero_ff;
   assign step_sel = req_if.direction ? ccw_phase_ff : cw_phase_ff;
   assign mech_in[0] = pos + zero_sel;
   assign mech_in[1] = mech_in[0] + step_sel;
   assign mech_in[2] = mech_in[0] + {step_sel[ANGLE_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         red_ff[0]  <= red_in;
         duty_ff[0] <= req_if.duty;
         for (int k = 0; k < NUM_PHASES; k++) begin
            mech_ff[k] <= mech_in[k];
         end
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            red_ff[i] <= red_ff[i-1];
         end
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (en[i]) begin
            duty_ff[i] <= duty_ff[i-1];
         end
      end
   end

   for (genvar k = 0; k < NUM_PHASES; k++) begin : g_lane
      tspwm_lane u_lane (
         .clock      (clock),
         .ctl        (ctl),
         .pole_pairs (pole_pairs_ff),
         .mech_angle (mech_ff[k]),
         .duty       (duty_ff[STAGE_LAST-1]),
         .duty_out   (lane_duty[k])
      );
   end

   assign rsp_if.valid            = valid_ff[STAGE_LAST];
   assign rsp_if.duty_a           = lane_duty[0];
   assign rsp_if.duty_b           = lane_duty[1];
   assign rsp_if.duty_c           = lane_duty[2];
   assign rsp_if.reduced_position = red_ff[STAGE_LAST];

   `ASSERT_PROP(a_accept_fills_stage0, clock, reset,
      (req_if.valid && req_if.ready) |=> valid_ff[0])
   `ASSERT_PROP(a_stall_holds_stage0, clock, reset,
      (valid_ff[0] && !en[1]) |=> (valid_ff[0] && $stable(red_ff[0])))
   `ASSERT_PROP(a_empty_after_reset, clock, reset,
      $past(reset) |-> (valid_ff == '0))
   `ASSERT_PROP(a_ready_when_room, clock, reset,
      ($countones(valid_ff) < NUM_STAGES) |-> req_if.ready)

endmodule
